@@ hdl/protobuf_scalar_field_encoder_defines.svh @@
// assertion macros for the protobuf scalar field encoder
// no dependencies; included by the top level only
`ifndef PROTOBUF_SCALAR_FIELD_ENCODER_DEFINES_SVH
`define PROTOBUF_SCALAR_FIELD_ENCODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PSFE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("psfe assertion failed");

// next-cycle implication, disabled during reset
`define PSFE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("psfe assertion failed");

`endif

@@ hdl/psfe_pkg.sv @@
// shared types and constants for the protobuf scalar field encoder
// no dependencies
package psfe_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 4;
    localparam logic [CNT_W-1:0] VARINT_LAST_IDX = 4'd9;
    localparam logic [CNT_W-1:0] FIXED32_LAST_IDX = 4'd3;
    localparam logic [CNT_W-1:0] FIXED64_LAST_IDX = 4'd7;
    localparam logic [7:0] CONT_BIT = 8'h80;

    typedef enum logic [3:0] {
        CMD_UINT64   = 4'd0,
        CMD_UINT32   = 4'd1,
        CMD_INT32    = 4'd2,
        CMD_INT64    = 4'd3,
        CMD_SINT32   = 4'd4,
        CMD_SINT64   = 4'd5,
        CMD_FIXED32  = 4'd6,
        CMD_FIXED64  = 4'd7,
        CMD_SFIXED32 = 4'd8,
        CMD_SFIXED64 = 4'd9,
        CMD_BOOL     = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        JOB_VARINT = 2'd0,
        JOB_FIXED  = 2'd1,
        JOB_ERROR  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        wide;
        logic [63:0] word;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic             busy;
        job_kind_t        out_kind;
        logic [CNT_W-1:0] cnt;
    } back_status_t;

endpackage

@@ hdl/psfe_front.sv @@
// front end: range checks the value, applies zigzag and picks the wire form
// depends on psfe_pkg
module psfe_front import psfe_pkg::*; (
    input  logic [3:0]  s_cmd,
    input  logic [63:0] s_value_bits,
    output job_t        job
);

    logic fits_u32;
    logic fits_s32;
    logic [31:0] zz32;
    logic [63:0] zz64;

    assign fits_u32 = ~|s_value_bits[63:32];
    assign fits_s32 = (~|s_value_bits[63:31]) | (&s_value_bits[63:31]);
    assign zz32 = {s_value_bits[30:0], 1'b0} ^ {32{s_value_bits[31]}};
    assign zz64 = {s_value_bits[62:0], 1'b0} ^ {64{s_value_bits[63]}};

    always_comb begin
        job.kind = JOB_ERROR;
        job.wide = 1'b0;
        job.word = '0;
        unique case (cmd_t'(s_cmd))
            CMD_UINT64, CMD_INT64: begin
                job.kind = JOB_VARINT;
                job.word = s_value_bits;
            end
            CMD_UINT32: begin
                job.kind = fits_u32 ? JOB_VARINT : JOB_ERROR;
                job.word = s_value_bits;
            end
            CMD_INT32: begin
                job.kind = fits_s32 ? JOB_VARINT : JOB_ERROR;
                job.word = s_value_bits;
            end
            CMD_SINT32: begin
                job.kind = fits_s32 ? JOB_VARINT : JOB_ERROR;
                job.word = {32'd0, zz32};
            end
            CMD_SINT64: begin
                job.kind = JOB_VARINT;
                job.word = zz64;
            end
            CMD_FIXED32: begin
                job.kind = fits_u32 ? JOB_FIXED : JOB_ERROR;
                job.word = s_value_bits;
            end
            CMD_SFIXED32: begin
                job.kind = fits_s32 ? JOB_FIXED : JOB_ERROR;
                job.word = s_value_bits;
            end
            CMD_FIXED64, CMD_SFIXED64: begin
                job.kind = JOB_FIXED;
                job.wide = 1'b1;
                job.word = s_value_bits;
            end
            CMD_BOOL: begin
                job.kind = JOB_VARINT;
                job.word = {63'd0, |s_value_bits};
            end
            default: begin
                job.kind = JOB_ERROR;
            end
        endcase
    end

endmodule

@@ hdl/psfe_queue.sv @@
// short job queue between the front end and the byte emitter
// depends on psfe_pkg
module psfe_queue import psfe_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          pop_job,
    output queue_status_t status
);

    job_t mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic do_push;
    logic do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push = push & ~status.full;
    assign do_pop  = pop & ~status.empty;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
        end
    end

endmodule

@@ hdl/psfe_back.sv @@
// back end: takes jobs from the queue and emits one wire byte per beat
// depends on psfe_pkg
module psfe_back import psfe_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  job_t          job,
    input  logic          q_empty,
    output logic          pop,
    output back_status_t  status,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_last,
    output logic          m_range_error
);

    logic             busy_reg;
    job_kind_t        kind_reg;
    logic             wide_reg;
    logic [63:0]      word_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    logic [7:0]       m_out_byte_reg;
    logic             m_last_reg;
    logic             m_err_reg;
    job_kind_t        out_kind_reg;

    logic        out_free;
    logic        emit;
    logic [7:0]  beat_byte;
    logic        beat_last;
    logic        beat_err;
    logic [63:0] word_next;

    assign out_free = ~m_valid_reg | m_ready;
    assign pop      = ~busy_reg & ~q_empty;
    assign emit     = busy_reg & out_free;

    always_comb begin
        beat_byte = '0;
        beat_last = 1'b1;
        beat_err  = 1'b0;
        word_next = word_reg;
        unique case (kind_reg)
            JOB_VARINT: begin
                beat_last = ~|word_reg[63:7] | (cnt_reg == VARINT_LAST_IDX);
                beat_byte = {1'b0, word_reg[6:0]} | (beat_last ? 8'd0 : CONT_BIT);
                word_next = {7'd0, word_reg[63:7]};
            end
            JOB_FIXED: begin
                beat_last = (cnt_reg == (wide_reg ? FIXED64_LAST_IDX : FIXED32_LAST_IDX));
                beat_byte = word_reg[7:0];
                word_next = {8'd0, word_reg[63:8]};
            end
            JOB_ERROR: begin
                beat_err = 1'b1;
            end
            default: begin
                beat_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg <= 1'b1;
                kind_reg <= job.kind;
                wide_reg <= job.wide;
                word_reg <= job.word;
                cnt_reg  <= '0;
            end
            if (out_free) begin
                m_valid_reg <= emit;
            end
            if (emit) begin
                m_out_byte_reg <= beat_byte;
                m_last_reg     <= beat_last;
                m_err_reg      <= beat_err;
                out_kind_reg   <= kind_reg;
                word_reg       <= word_next;
                cnt_reg        <= cnt_reg + CNT_W'(1);
                if (beat_last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_out_byte_reg;
    assign m_last          = m_last_reg;
    assign m_range_error   = m_err_reg;
    assign status.busy     = busy_reg;
    assign status.out_kind = out_kind_reg;
    assign status.cnt      = cnt_reg;

endmodule

@@ hdl/protobuf_scalar_field_encoder.sv @@
// Protobuf scalar field encoder: one beat in (type code and 64-bit value), one wire byte
// per beat out, final byte flagged by m_last. A value takes one beat per wire byte
// (1 to 10), and the emitter loads the next job from the two-entry queue only after
// emitting the last byte of the current one; its single output register holds while
// m_ready is low. A range error gives a single beat with zero byte, last and error set.
// depends on psfe_pkg, psfe_front, psfe_queue, psfe_back and the defines header
`include "protobuf_scalar_field_encoder_defines.svh"

module protobuf_scalar_field_encoder import psfe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_cmd,
    input  logic [63:0] s_value_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    output logic        m_range_error
);

    job_t          front_job;
    job_t          q_job;
    queue_status_t q_status;
    back_status_t  back_status;
    logic          q_pop;
    logic          out_err;
    logic          out_varint_mid;
    logic          cnt_in_range;

    psfe_front u_front (
        .s_cmd        (s_cmd),
        .s_value_bits (s_value_bits),
        .job          (front_job)
    );

    psfe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid),
        .push_job (front_job),
        .pop      (q_pop),
        .pop_job  (q_job),
        .status   (q_status)
    );

    psfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job           (q_job),
        .q_empty       (q_status.empty),
        .pop           (q_pop),
        .status        (back_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .m_range_error (m_range_error)
    );

    assign s_ready = ~q_status.full;

    assign out_err        = m_valid & m_range_error;
    assign out_varint_mid = m_valid & ~m_last & (back_status.out_kind == JOB_VARINT);
    assign cnt_in_range   = (back_status.cnt <= VARINT_LAST_IDX);

    `PSFE_ASSERT_NOW(a_err_single_beat, aclk, aresetn, out_err, m_last && m_out_byte == 8'd0)
    `PSFE_ASSERT_NOW(a_varint_cont, aclk, aresetn, out_varint_mid, m_out_byte[7])
    `PSFE_ASSERT_NOW(a_cnt_bound, aclk, aresetn, back_status.busy, cnt_in_range)
    `PSFE_ASSERT_NEXT(a_pop_loads, aclk, aresetn, q_pop, back_status.busy)

endmodule
